// ----- sv/bounded_deque_defines.svh -----
// Assertion macros for the bounded deque RTL.
`ifndef BOUNDED_DEQUE_DEFINES_SVH
`define BOUNDED_DEQUE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BDQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bounded_deque: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define BDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bounded_deque: next-cycle check failed");

`endif

// ----- sv/bdq_pkg.sv -----
// Package: sizes, codes and transaction types of the bounded deque.
`default_nettype none
package bdq_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int CAP_W = 7;
  localparam int OCC_W = 7;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_REAR  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_REAR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_SHIFT_IN  = 2'd1,
    CELL_SHIFT_OUT = 2'd2,
    CELL_LOAD_REAR = 2'd3
  } cell_op_t;

  typedef struct packed {
    action_t                  action;
    logic signed [VAL_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    status_t                  status;
    logic signed [VAL_W-1:0]  popped_value;
    logic [OCC_W-1:0]         occupancy;
  } out_item_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    cell_op_t                 op;
    logic signed [VAL_W-1:0]  value;
    logic [CNT_W-1:0]         count;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- sv/bdq_cell.sv -----
// One storage cell of the deque chain: holds one entry, moves with its neighbors.
`default_nettype none
module bdq_cell (
  input  wire logic                                  clk,
  input  wire bdq_pkg::cell_ctl_t                    ctl,
  input  wire logic [bdq_pkg::IDX_W-1:0]             idx,
  input  wire logic signed [bdq_pkg::VAL_W-1:0]      left_data,
  input  wire logic signed [bdq_pkg::VAL_W-1:0]      right_data,
  output logic signed [bdq_pkg::VAL_W-1:0]           data_q,
  output logic                                       is_rear
);
  import bdq_pkg::*;

  logic signed [VAL_W-1:0] data_r;
  logic signed [VAL_W-1:0] data_nxt;
  logic                    at_count;

  assign at_count = (CNT_W'(idx) == ctl.count);
  assign is_rear  = ((CNT_W'(idx) + CNT_W'(1)) == ctl.count);
  assign data_q   = data_r;

  always_comb begin
    data_nxt = data_r;
    unique case (ctl.op)
      CELL_HOLD:      data_nxt = data_r;
      CELL_SHIFT_IN:  data_nxt = (idx == '0) ? ctl.value : left_data;
      CELL_SHIFT_OUT: data_nxt = right_data;
      CELL_LOAD_REAR: data_nxt = at_count ? ctl.value : data_r;
      default:        data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule
`default_nettype wire

// ----- sv/bounded_deque.sv -----
// Top level of the bounded deque: control, cell chain and result register.
// The deque is a row of DEPTH cells with the front entry always in cell 0.
// A push at the front shifts every entry one cell toward the rear; a pop at
// the front shifts them back; a push at the rear writes the cell just past
// the last entry, and a pop at the rear reads the last entry and drops it
// from the count. The usable size is the smaller of the capacity register
// (reset 64) and DEPTH. Every accepted transaction gives exactly one result
// in the next cycle: status, popped value (zero unless a pop succeeded) and
// the occupancy after the step. One transaction is taken per cycle; the
// single result register sets that rate, so the input stalls only while a
// result waits and the output side is stalling. Write capacity on the
// cfg_ channel only while the block is idle.
`default_nettype none
`include "bounded_deque_defines.svh"
module bounded_deque (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire bdq_pkg::in_item_t             in_item,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output bdq_pkg::out_item_t                 out_item,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bdq_pkg::CAP_W-1:0]     cfg_capacity
);
  import bdq_pkg::*;

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [CAP_W-1:0]        cap_r;
  logic                    out_valid_r;
  out_item_t               out_r, out_nxt;
  logic                    in_acc;
  logic                    full, empty;
  cell_ctl_t               ctl;
  logic signed [VAL_W-1:0] cell_data [DEPTH];
  logic                    cell_rear [DEPTH];
  logic signed [VAL_W-1:0] rear_data;

  // Take a new transaction whenever the result register is free or draining.
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Full when the count reaches the capacity or the physical depth.
  assign full  = (CMP_W'(cnt_r) >= CMP_W'(cap_r)) || (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);

  // Select the rear entry: exactly one cell flags itself when the deque is not empty.
  always_comb begin
    rear_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_data = rear_data | (cell_data[i] & {VAL_W{cell_rear[i]}});
    end
  end

  // Decode the transaction into a chain command, new count and result.
  always_comb begin
    ctl.op    = CELL_HOLD;
    ctl.value = in_item.value;
    ctl.count = cnt_r;
    cnt_nxt   = cnt_r;
    out_nxt.status       = STAT_OK;
    out_nxt.popped_value = '0;
    unique case (in_item.action)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (full) begin
          out_nxt.status = STAT_FULL;
        end else begin
          ctl.op  = (in_item.action == ACT_PUSH_FRONT) ? CELL_SHIFT_IN : CELL_LOAD_REAR;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ACT_POP_FRONT, ACT_POP_REAR: begin
        if (empty) begin
          out_nxt.status = STAT_EMPTY;
        end else begin
          // Drop the rear entry by count alone; the front pop shifts the chain.
          ctl.op  = (in_item.action == ACT_POP_FRONT) ? CELL_SHIFT_OUT : CELL_HOLD;
          out_nxt.popped_value = (in_item.action == ACT_POP_FRONT) ? cell_data[0] : rear_data;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
    if (!in_acc) begin
      ctl.op  = CELL_HOLD;
      cnt_nxt = cnt_r;
    end
    out_nxt.occupancy = OCC_W'(cnt_nxt);
  end

  // Row of cells; the last cell takes zero when the chain shifts toward the front.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_d, right_d;
    if (g == 0) begin : g_first
      assign left_d = ctl.value;
    end else begin : g_mid
      assign left_d = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cell_data[g+1];
    end
    bdq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (IDX_W'(g)),
      .left_data  (left_d),
      .right_data (right_d),
      .data_q     (cell_data[g]),
      .is_rear    (cell_rear[g])
    );
  end

  // Hold count and capacity; advance the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= out_nxt;
    end
  end

  `BDQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(DEPTH))
  `BDQ_ASSERT_NEXT(a_full_keeps, in_acc && !in_item.action[1] && full, cnt_r == $past(cnt_r) && out_r.status == STAT_FULL)
  `BDQ_ASSERT_NEXT(a_pop_count, in_acc && in_item.action[1] && !empty, out_valid_r && out_r.occupancy == OCC_W'($past(cnt_r) - CNT_W'(1)))
  `BDQ_ASSERT_NEXT(a_empty_zero, in_acc && in_item.action[1] && empty, out_r.status == STAT_EMPTY && out_r.popped_value == '0)

endmodule
`default_nettype wire
